@@ rtl/hfs_pkg.sv @@
// Shared types and constants for the frame sync / channel extract block.
// No dependencies.
package hfs_pkg;

  localparam int unsigned BLOCK_WORDS  = 11090;
  localparam int unsigned NUM_CHANNELS = 5;
  localparam int unsigned SCAN_WIDTH   = 2048;
  localparam int unsigned IMAGE_START  = 750;
  localparam int unsigned SYNC_LEN     = 6;
  localparam int unsigned IMAGE_END    = IMAGE_START + NUM_CHANNELS * SCAN_WIDTH;

  localparam int unsigned WORD_W  = 16;
  localparam int unsigned GAIN_W  = 8;
  localparam int unsigned CHAN_W  = 3;
  localparam int unsigned MATCH_W = 3;
  localparam int unsigned POS_W   = 14;
  localparam int unsigned PIX_W   = 11;
  localparam int unsigned LINE_W  = 16;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned PROD_W  = WORD_W + GAIN_W;

  typedef logic [WORD_W-1:0]  word_t;
  typedef logic [GAIN_W-1:0]  gain_t;
  typedef logic [CHAN_W-1:0]  chan_t;
  typedef logic [MATCH_W-1:0] match_t;
  typedef logic [POS_W-1:0]   pos_t;
  typedef logic [PIX_W-1:0]   pix_t;
  typedef logic [LINE_W-1:0]  line_t;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_SELECT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_GAIN     = 2'd1;

  localparam chan_t CHANNEL_SELECT_RST = 3'd1;
  localparam gain_t PIXEL_GAIN_RST     = 8'd60;

  // result kinds
  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_SYNC  = 1'b1;

  localparam word_t SYNC_WORDS [8] = '{
    16'h0284, 16'h016F, 16'h035C, 16'h019D,
    16'h020F, 16'h0095, 16'h0000, 16'h0000
  };

  typedef struct packed {
    logic  kind;
    word_t value;
    pix_t  index;
    line_t line;
    logic  last;
  } result_t;

endpackage

@@ rtl/hfs_sync_match.sv @@
// Frame sync pattern matcher: tracks how many sync words matched in a row.
// Depends on hfs_pkg.
module hfs_sync_match
  import hfs_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  step,
  input  word_t word,
  output logic  detect
);

  match_t matched_r;
  match_t matched_nxt;
  match_t count;

  always_comb begin
    if (word == SYNC_WORDS[matched_r]) begin
      count = matched_r + match_t'(1);
    end else if (word == SYNC_WORDS[0]) begin
      // a slip onto the first sync word restarts the match at one
      count = match_t'(1);
    end else begin
      count = '0;
    end
    detect      = ({1'b0, count} >= (MATCH_W+1)'(SYNC_LEN));
    matched_nxt = detect ? '0 : count;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      matched_r <= '0;
    end else if (step) begin
      matched_r <= matched_nxt;
    end
  end

endmodule

@@ rtl/hfs_pixel_scale.sv @@
// Pixel gain: word times gain, saturated to the word width.
// Depends on hfs_pkg.
module hfs_pixel_scale
  import hfs_pkg::*;
(
  input  word_t word,
  input  gain_t gain,
  output word_t value
);

  logic [PROD_W-1:0] prod;

  always_comb begin
    prod  = PROD_W'(word) * PROD_W'(gain);
    value = (prod[PROD_W-1:WORD_W] != '0) ? '1 : prod[WORD_W-1:0];
  end

endmodule

@@ rtl/hrpt_frame_sync_channel_extract.sv @@
// Frame sync detection and image channel extraction, top level.
// Depends on hfs_pkg, hfs_sync_match and hfs_pixel_scale.
//
// One 16-bit telemetry word is taken per clock; each word passes an input
// register, the combinational match/count logic and a result register; the
// sustained rate is one word per cycle as long as out_ready stays high. A
// result with result_kind 1 marks a frame sync detection; pixel results
// appear only after the first sync, for words of the selected channel in
// the image section. Configuration writes are taken every cycle (cfg_ready
// is high) and must only occur while the block holds no pending word or
// result.
module hrpt_frame_sync_channel_extract
  import hfs_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  word_t                in_data_word,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_result_kind,
  output word_t                out_pixel_value,
  output pix_t                 out_pixel_index,
  output line_t                out_line_number,
  output logic                 out_last_in_line,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data
);

  chan_t   channel_select_r;
  gain_t   pixel_gain_r;

  logic    in_valid_r;
  word_t   word_r;

  logic    locked_r,  locked_nxt;
  pos_t    pos_r,     pos_nxt;
  chan_t   phase_r,   phase_nxt;
  pix_t    pix_r,     pix_nxt;
  line_t   frame_r,   frame_nxt;

  logic    out_valid_r, out_valid_nxt;
  result_t res_r, res_nxt;

  logic    advance;
  logic    fire;
  logic    detect;
  logic    hit;
  logic    in_image;
  chan_t   phase_base;
  pix_t    pix_base;
  word_t   scaled;
  logic [POS_W:0] pos_inc;

  assign cfg_ready = 1'b1;
  assign advance   = !out_valid_r || out_ready;
  assign fire      = in_valid_r && advance;
  assign in_ready  = !in_valid_r || advance;

  hfs_sync_match u_match (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (fire),
    .word   (word_r),
    .detect (detect)
  );

  hfs_pixel_scale u_scale (
    .word  (word_r),
    .gain  (pixel_gain_r),
    .value (scaled)
  );

  always_comb begin
    phase_base = (pos_r == POS_W'(IMAGE_START)) ? '0 : phase_r;
    pix_base   = (pos_r == POS_W'(IMAGE_START)) ? '0 : pix_r;
    in_image   = ({1'b0, pos_r} >= (POS_W+1)'(IMAGE_START)) &&
                 ({1'b0, pos_r} <  (POS_W+1)'(IMAGE_END));
    hit        = in_image && ({1'b0, phase_base} + 4'd1 == {1'b0, channel_select_r});
    pos_inc    = {1'b0, pos_r} + (POS_W+1)'(1);

    locked_nxt = locked_r;
    pos_nxt    = pos_r;
    phase_nxt  = phase_r;
    pix_nxt    = pix_r;
    frame_nxt  = frame_r;
    out_valid_nxt = out_ready ? 1'b0 : out_valid_r;
    res_nxt    = res_r;

    if (fire) begin
      out_valid_nxt = 1'b0;
      if (detect) begin
        frame_nxt  = (frame_r != '1) ? frame_r + line_t'(1) : frame_r;
        locked_nxt = 1'b1;
        pos_nxt    = (SYNC_LEN >= BLOCK_WORDS) ? '0 : POS_W'(SYNC_LEN);
        phase_nxt  = '0;
        pix_nxt    = '0;
        out_valid_nxt = 1'b1;
        res_nxt    = '{kind: KIND_SYNC, value: '0, index: '0,
                       line: frame_nxt, last: 1'b0};
      end else if (locked_r) begin
        phase_nxt = phase_base;
        pix_nxt   = pix_base;
        if (in_image) begin
          if (hit) begin
            out_valid_nxt = 1'b1;
            res_nxt = '{kind: KIND_PIXEL, value: scaled, index: pix_base,
                        line: frame_r,
                        last: (pix_base == PIX_W'(SCAN_WIDTH - 1))};
          end
          if ({1'b0, phase_base} + 4'd1 >= 4'(NUM_CHANNELS)) begin
            phase_nxt = '0;
            pix_nxt   = pix_base + pix_t'(1);
          end else begin
            phase_nxt = phase_base + chan_t'(1);
          end
        end
        pos_nxt = (pos_inc >= (POS_W+1)'(BLOCK_WORDS)) ? '0 : pos_inc[POS_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      channel_select_r <= CHANNEL_SELECT_RST;
      pixel_gain_r     <= PIXEL_GAIN_RST;
      in_valid_r       <= 1'b0;
      locked_r         <= 1'b0;
      pos_r            <= '0;
      phase_r          <= '0;
      pix_r            <= '0;
      frame_r          <= '0;
      out_valid_r      <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_CHANNEL_SELECT: channel_select_r <= cfg_data[CHAN_W-1:0];
          CFG_PIXEL_GAIN:     pixel_gain_r     <= cfg_data[GAIN_W-1:0];
          default: ;
        endcase
      end
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      locked_r    <= locked_nxt;
      pos_r       <= pos_nxt;
      phase_r     <= phase_nxt;
      pix_r       <= pix_nxt;
      frame_r     <= frame_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      word_r <= in_data_word;
    end
    res_r <= res_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_result_kind  = res_r.kind;
  assign out_pixel_value  = res_r.value;
  assign out_pixel_index  = res_r.index;
  assign out_line_number  = res_r.line;
  assign out_last_in_line = res_r.last;

endmodule

@@ verif/hrpt_frame_sync_channel_extract_test.sv @@
// Self-checking testbench for hrpt_frame_sync_channel_extract.
// Needs hfs_pkg and the block's RTL; drives words and register writes,
// predicts sync/pixel transactions and checks them as they come out.
`timescale 1ns / 1ps

module hrpt_frame_sync_channel_extract_test;
  import hfs_pkg::*;

  localparam int QUIET_LIMIT   = 4000;  // cycles with no transaction at all
  localparam int SETTLE_CYCLES = 8;     // two-stage pipe plus margin
  localparam logic [CFG_IDX_W-1:0] CFG_NO_REG = 2'd3;  // unmapped index

  // sync slip, broken sync, repeated first sync word
  localparam word_t OPENING_WORDS [24] = '{
    16'h0000, 16'hFFFF,
    16'h0284, 16'h016F, 16'h035C, 16'h0284, 16'h016F, 16'h035C,
    16'h019D, 16'h020F, 16'h0095,
    16'h0284, 16'h016F, 16'h035C, 16'h019D, 16'h020F, 16'h0000,
    16'h0284, 16'h0284, 16'h016F, 16'h035C, 16'h019D, 16'h020F, 16'h0095
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                 in_valid = 1'b0;
  logic                 in_ready;
  word_t                in_data_word = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 out_result_kind;
  word_t                out_pixel_value;
  pix_t                 out_pixel_index;
  line_t                out_line_number;
  logic                 out_last_in_line;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [7:0]           cfg_data = '0;

  hrpt_frame_sync_channel_extract DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data_word(in_data_word),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_result_kind(out_result_kind), .out_pixel_value(out_pixel_value),
    .out_pixel_index(out_pixel_index), .out_line_number(out_line_number),
    .out_last_in_line(out_last_in_line),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // deframer state as the block should hold it
  match_t sync_hits   = '0;
  logic   is_locked   = 1'b0;
  pos_t   word_pos    = '0;
  chan_t  ilv_phase   = '0;
  pix_t   pix_count   = '0;
  line_t  frame_count = '0;
  chan_t  sel_channel = CHANNEL_SELECT_RST;
  gain_t  gain        = PIXEL_GAIN_RST;

  word_t   words_to_send [$];
  result_t frame_results_due [$];

  int words_queued   = 0;
  int words_accepted = 0;
  int cfg_writes     = 0;
  int errors         = 0;
  int syncs_seen     = 0;
  int pixels_seen    = 0;
  int line_ends_seen = 0;
  int results_seen   = 0;
  line_t top_line    = '0;
  logic idle_on      = 1'b1;

  // Advance the deframer by one word; queue the transaction it causes, if any.
  function automatic void deframe_word(word_t w);
    result_t r;
    logic [PROD_W-1:0] prod;
    if (w == SYNC_WORDS[sync_hits]) sync_hits = sync_hits + 1'b1;
    else sync_hits = (w == SYNC_WORDS[0]) ? match_t'(1) : match_t'(0);

    if (sync_hits >= SYNC_LEN) begin
      sync_hits = '0;
      if (frame_count != '1) frame_count = frame_count + 1'b1;
      is_locked = 1'b1;
      word_pos  = pos_t'(SYNC_LEN);
      ilv_phase = '0;
      pix_count = '0;
      r = '{kind: KIND_SYNC, value: '0, index: '0, line: frame_count, last: 1'b0};
      frame_results_due.push_back(r);
      return;
    end
    if (!is_locked) return;

    if (word_pos == IMAGE_START) begin
      ilv_phase = '0;
      pix_count = '0;
    end
    if (word_pos >= IMAGE_START && word_pos < IMAGE_END) begin
      if (int'(ilv_phase) + 1 == int'(sel_channel)) begin
        prod = w * gain;
        r.kind  = KIND_PIXEL;
        r.value = (prod > 24'hFFFF) ? 16'hFFFF : prod[WORD_W-1:0];
        r.index = pix_count;
        r.line  = frame_count;
        r.last  = (pix_count == SCAN_WIDTH - 1);
        frame_results_due.push_back(r);
      end
      ilv_phase = ilv_phase + 1'b1;
      if (ilv_phase >= NUM_CHANNELS) begin
        ilv_phase = '0;
        pix_count = pix_count + 1'b1;
      end
    end
    word_pos = (word_pos + 1 >= BLOCK_WORDS) ? pos_t'(0) : pos_t'(word_pos + 1);
  endfunction

  // ---------------- driver ----------------
  int gap_left = 0;
  bit drain_hold = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        deframe_word(in_data_word);
        words_accepted++;
        gap_left = idle_on ? $urandom_range(0, 4) : 0;
        // now and then let the pipe run dry before the next word
        if (words_accepted % 1500 == 0) drain_hold = 1'b1;
      end
      if (!(in_valid && !in_ready)) begin
        if (drain_hold && frame_results_due.size() == 0) drain_hold = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (drain_hold || words_to_send.size() == 0) begin
          in_valid <= 1'b0;
        end else begin
          in_valid     <= 1'b1;
          in_data_word <= words_to_send.pop_front();
        end
      end
    end
  end

  // ---------------- monitor ----------------
  int stall_left = 0;
  int hold_left  = 0;

  task automatic check_field(string field, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (frame_results_due.size() == 0) begin
          $display("%0t: unexpected transaction kind=%0d value=%0d index=%0d line=%0d last=%0d",
                   $time, out_result_kind, out_pixel_value, out_pixel_index,
                   out_line_number, out_last_in_line);
          errors++;
        end else begin
          want = frame_results_due.pop_front();
          check_field("result_kind", want.kind, out_result_kind);
          check_field("pixel_value", want.value, out_pixel_value);
          check_field("pixel_index", want.index, out_pixel_index);
          check_field("line_number", want.line, out_line_number);
          check_field("last_in_line", want.last, out_last_in_line);
          if (want.kind == KIND_SYNC) syncs_seen++;
          else pixels_seen++;
          if (want.last) line_ends_seen++;
          if (want.line > top_line) top_line = want.line;
          // long back-pressure in a pixel run so the input side fills and stalls
          if (want.kind == KIND_PIXEL && pixels_seen == 10) hold_left = 250;
        end
        stall_left = idle_on ? $urandom_range(0, 4) : 0;
        if (hold_left == 0 && idle_on && $urandom_range(0, 399) == 0)
          hold_left = $urandom_range(100, 300);
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // ---------------- watchdog ----------------
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles == QUIET_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  // ---------------- stimulus ----------------
  function automatic void push_word(word_t w);
    words_to_send.push_back(w);
    words_queued++;
  endfunction

  function automatic word_t pick_word();
    int unsigned r = $urandom_range(0, 99);
    if (r < 45) return word_t'($urandom);
    if (r < 70) return word_t'($urandom_range(0, 300));
    if (r < 80) return word_t'($urandom_range(0, 4000));
    if (r < 90) return SYNC_WORDS[$urandom_range(0, SYNC_LEN - 1)];
    if (r < 95) return '0;
    return '1;
  endfunction

  // mostly long enough to get into the image section
  function automatic int pick_body_len();
    int unsigned r = $urandom_range(0, 99);
    if (r < 55) return $urandom_range(IMAGE_START, IMAGE_START + 250);
    if (r < 75) return $urandom_range(0, 12);
    return $urandom_range(13, IMAGE_START - 1);
  endfunction

  // sync pattern (sometimes slipped or broken) followed by body words
  function automatic int queue_frame(int body_len);
    int unsigned r   = $urandom_range(0, 9);
    int unsigned bad = $urandom_range(0, SYNC_LEN - 1);
    int n = 0;
    if (r == 0) begin
      push_word(SYNC_WORDS[0]);
      n++;
    end
    for (int k = 0; k < SYNC_LEN; k++) begin
      push_word((r == 1 && k == bad) ? pick_word() : SYNC_WORDS[k]);
      n++;
    end
    for (int k = 0; k < body_len; k++) push_word(pick_word());
    return n + body_len;
  endfunction

  function automatic void queue_random(int n_words);
    int pushed = 0;
    int body;
    while (pushed < n_words) begin
      body = pick_body_len();
      // keep the total close to the budget
      if (pushed + body + int'(SYNC_LEN) + 1 > n_words)
        body = n_words - pushed - int'(SYNC_LEN) - 1;
      if (body < 0) body = 0;
      pushed += queue_frame(body);
    end
  endfunction

  // body words only: the flywheel carries the position on from the last sync
  function automatic void queue_body(int n_words);
    for (int k = 0; k < n_words; k++) push_word(pick_word());
  endfunction

  task automatic wait_idle();
    while (words_accepted != words_queued || frame_results_due.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_CHANNEL_SELECT) sel_channel = val[CHAN_W-1:0];
    else if (idx == CFG_PIXEL_GAIN) gain = val;
    cfg_writes++;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (OPENING_WORDS[k]) push_word(OPENING_WORDS[k]);
    wait_idle();

    queue_random(400);
    wait_idle();

    // clean sync, then run into the image section
    write_reg(CFG_CHANNEL_SELECT, 8'd5);
    write_reg(CFG_PIXEL_GAIN, 8'd255);
    for (int j = 0; j < SYNC_LEN; j++) push_word(SYNC_WORDS[j]);
    queue_body(IMAGE_START + 150);
    wait_idle();

    // the body-only runs that follow stay inside the image section on the same frame
    write_reg(CFG_CHANNEL_SELECT, 8'd3);
    write_reg(CFG_PIXEL_GAIN, 8'd0);
    write_reg(CFG_NO_REG, 8'hAA);
    queue_body(100);
    wait_idle();

    write_reg(CFG_CHANNEL_SELECT, 8'd0);
    write_reg(CFG_PIXEL_GAIN, 8'd128);
    queue_body(60);
    wait_idle();

    write_reg(CFG_CHANNEL_SELECT, 8'hFF);
    queue_body(40);
    wait_idle();

    idle_on <= 1'b0;
    write_reg(CFG_CHANNEL_SELECT, 8'd4);
    write_reg(CFG_PIXEL_GAIN, 8'd17);
    queue_body(150);
    wait_idle();

    write_reg(CFG_CHANNEL_SELECT, 8'hFD);
    write_reg(CFG_PIXEL_GAIN, 8'd2);
    queue_body(100);
    queue_random(250);
    wait_idle();

    $display("Run covered %0d words, %0d register writes, %0d sync detections,",
             words_accepted, cfg_writes, syncs_seen);
    $display("%0d pixels with %0d line ends, highest line number %0d.",
             pixels_seen, line_ends_seen, top_line);
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
